// ----- hdl/label_propagation_communities_unit_defines.svh -----
// assertion macros used by the checker file
`ifndef LABEL_PROPAGATION_COMMUNITIES_UNIT_DEFINES_SVH
`define LABEL_PROPAGATION_COMMUNITIES_UNIT_DEFINES_SVH

// same-cycle implication, disabled in reset
`define LPC_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("assertion failed");

// next-cycle implication, disabled in reset
`define LPC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// ----- hdl/lpc_pkg.sv -----
`default_nettype none
package lpc_pkg;
    localparam int VERTEX_SLOTS = 64;
    localparam int VW = $clog2(VERTEX_SLOTS);
    localparam int CW = VW + 1;
    localparam logic [6:0] VCOUNT_RESET = 7'd64;
    localparam logic [7:0] MAX_ITER_RESET = 8'd10;
    localparam logic CFG_VERTEX_COUNT = 1'b0;
    localparam logic CFG_MAX_ITER = 1'b1;

    typedef enum logic [1:0] {
        CMD_ADD   = 2'd0,
        CMD_RUN   = 2'd1,
        CMD_READ  = 2'd2,
        CMD_CLEAR = 2'd3
    } t_cmd;

    typedef struct packed {
        t_cmd       command;
        logic [5:0] src_vertex;
        logic [5:0] dst_vertex;
    } t_in;

    typedef struct packed {
        logic [5:0] vertex_community;
        logic [6:0] community_total;
        logic [7:0] sweeps_done;
        logic       is_run_report;
    } t_out;
endpackage
`default_nettype wire

// ----- hdl/lpc_ram.sv -----
`default_nettype none
module lpc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule
`default_nettype wire

// ----- hdl/label_propagation_communities_unit.sv -----
// add edge: write row a, read row b, write row b; clear acts in the idle state;
// read: label read, result staged, then the result register loaded
// run: label init of all 64 slots, then sweeps over the vertices in use, three
//   passes over the neighbours of each vertex that has them, then renumbering; throughput one item at a time
// reset (synchronous, active low): adjacency row valid bits cleared, labels
//   read as own index until the first run, totals zero, registers 64 and 10
`default_nettype none
module label_propagation_communities_unit (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_in_valid,
    output logic               o_in_stall,
    input  wire lpc_pkg::t_in  i_in_data,
    output logic               o_out_valid,
    input  wire logic          i_out_stall,
    output lpc_pkg::t_out      o_out_data,
    input  wire logic          i_cfg_we,
    input  wire logic          i_cfg_index,
    input  wire logic [7:0]    i_cfg_data
);
    localparam int NV = lpc_pkg::VERTEX_SLOTS;
    localparam int VW = lpc_pkg::VW;
    localparam int CW = lpc_pkg::CW;

    typedef enum logic [4:0] {
        S_IDLE, S_ADD_WA, S_ADD_RB, S_ADD_WB, S_RD_OUT, S_OUT,
        S_INIT, S_SW_START, S_V_START, S_V_ROW, S_P_SCAN, S_P_LAB, S_P_TAL,
        S_V_UPD, S_RN_INIT, S_RN_ISSUE, S_RN_OLD, S_RN_MAP
    } t_state;

    t_state r_state;

    // configuration registers
    logic [6:0] r_vcount;
    logic [7:0] r_max_iter;

    // command operands
    logic [VW-1:0] r_a, r_b;

    // adjacency row valid bits, renumber valid bits
    logic [NV-1:0] r_adj_valid;
    logic [NV-1:0] r_map_valid;

    // run working state
    logic [CW-1:0] r_v, r_u;
    logic [1:0]    r_pass;
    logic [NV-1:0] r_row;
    logic [VW-1:0] r_own, r_lab, r_best;
    logic [CW-1:0] r_best_cnt;
    logic          r_changed;
    logic [7:0]    r_sweeps;
    logic [CW-1:0] r_next;
    logic          r_ran;

    // results of the last run
    logic [6:0] r_last_total;
    logic [7:0] r_last_sweeps;

    // result staging and output register
    lpc_pkg::t_out r_res;
    logic          r_out_valid;
    lpc_pkg::t_out r_out;

    // ram ports
    logic          adj_we, lab_we, tal_we, map_we;
    logic [VW-1:0] adj_waddr, adj_raddr, lab_waddr, lab_raddr, tal_waddr, map_waddr;
    logic [NV-1:0] adj_wdata, adj_q, adj_base;
    logic [VW-1:0] lab_wdata, lab_q;
    logic [CW-1:0] tal_wdata, tal_q, map_wdata, map_q;

    // effective vertex count and row mask
    logic [CW-1:0] n_eff;
    logic [NV-1:0] cnt_mask;
    logic          in_acc, out_free;

    assign n_eff = (r_vcount > CW'(NV)) ? CW'(NV) : CW'(r_vcount);

    always_comb begin
        for (int k = 0; k < NV; k++) begin
            cnt_mask[k] = (CW'(k) < n_eff);
        end
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign in_acc      = i_in_valid && !o_in_stall;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;
    assign out_free    = !r_out_valid || !i_out_stall;

    // an invalid row reads as all zeros
    assign adj_base = r_adj_valid[adj_waddr] ? adj_q : '0;

    always_comb begin
        adj_raddr = r_a;
        adj_we    = 1'b0;
        adj_waddr = r_a;
        adj_wdata = adj_base | (NV'(1) << r_b);
        lab_raddr = r_a;
        lab_we    = 1'b0;
        lab_waddr = r_v[VW-1:0];
        lab_wdata = r_v[VW-1:0];
        tal_we    = 1'b0;
        tal_waddr = r_lab;
        tal_wdata = tal_q + CW'(1);
        map_we    = 1'b0;
        map_waddr = lab_q;
        map_wdata = r_next;
        case (r_state)
            S_IDLE: begin
                adj_raddr = i_in_data.src_vertex;
                lab_raddr = i_in_data.src_vertex;
            end
            S_ADD_WA: begin
                adj_we = 1'b1;
            end
            S_ADD_RB: begin
                adj_raddr = r_b;
            end
            S_ADD_WB: begin
                adj_we    = 1'b1;
                adj_waddr = r_b;
                adj_wdata = adj_base | (NV'(1) << r_a);
            end
            S_INIT: begin
                lab_we = 1'b1;
            end
            S_V_START: begin
                adj_raddr = r_v[VW-1:0];
                lab_raddr = r_v[VW-1:0];
            end
            S_P_SCAN: begin
                lab_raddr = r_u[VW-1:0];
            end
            S_P_LAB: begin
                // first pass zeroes the tally of each neighbour label
                if (r_pass == 2'd0) begin
                    tal_we    = 1'b1;
                    tal_waddr = lab_q;
                    tal_wdata = '0;
                end
            end
            S_P_TAL: begin
                tal_we = (r_pass == 2'd1);
            end
            S_V_UPD: begin
                lab_we    = (r_best != r_own);
                lab_wdata = r_best;
            end
            S_RN_ISSUE: begin
                lab_raddr = r_v[VW-1:0];
            end
            S_RN_OLD: begin
                if (!r_map_valid[lab_q]) begin
                    map_we    = 1'b1;
                    lab_we    = 1'b1;
                    lab_wdata = r_next[VW-1:0];
                end
            end
            S_RN_MAP: begin
                lab_we    = 1'b1;
                lab_wdata = map_q[VW-1:0];
            end
            default: begin
            end
        endcase
    end

    lpc_ram #(.WIDTH(NV), .DEPTH(NV)) u_adj (
        .i_clk(i_clk), .i_we(adj_we), .i_waddr(adj_waddr), .i_wdata(adj_wdata),
        .i_raddr(adj_raddr), .o_rdata(adj_q)
    );

    lpc_ram #(.WIDTH(VW), .DEPTH(NV)) u_label (
        .i_clk(i_clk), .i_we(lab_we), .i_waddr(lab_waddr), .i_wdata(lab_wdata),
        .i_raddr(lab_raddr), .o_rdata(lab_q)
    );

    // tally and renumber map are addressed by the label just read
    lpc_ram #(.WIDTH(CW), .DEPTH(NV)) u_tally (
        .i_clk(i_clk), .i_we(tal_we), .i_waddr(tal_waddr), .i_wdata(tal_wdata),
        .i_raddr(lab_q), .o_rdata(tal_q)
    );

    lpc_ram #(.WIDTH(CW), .DEPTH(NV)) u_map (
        .i_clk(i_clk), .i_we(map_we), .i_waddr(map_waddr), .i_wdata(map_wdata),
        .i_raddr(lab_q), .o_rdata(map_q)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_IDLE;
            r_vcount      <= lpc_pkg::VCOUNT_RESET;
            r_max_iter    <= lpc_pkg::MAX_ITER_RESET;
            r_adj_valid   <= '0;
            r_map_valid   <= '0;
            r_ran         <= 1'b0;
            r_last_total  <= '0;
            r_last_sweeps <= '0;
            r_out_valid   <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    lpc_pkg::CFG_VERTEX_COUNT: r_vcount   <= i_cfg_data[6:0];
                    lpc_pkg::CFG_MAX_ITER:     r_max_iter <= i_cfg_data;
                    default: begin
                    end
                endcase
            end
            // the output state reloads the register itself
            if (r_out_valid && !i_out_stall && (r_state != S_OUT)) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (in_acc) begin
                        r_a <= i_in_data.src_vertex;
                        r_b <= i_in_data.dst_vertex;
                        case (i_in_data.command)
                            lpc_pkg::CMD_ADD:   r_state <= S_ADD_WA;
                            lpc_pkg::CMD_RUN: begin
                                r_v     <= '0;
                                r_state <= S_INIT;
                            end
                            lpc_pkg::CMD_READ:  r_state <= S_RD_OUT;
                            lpc_pkg::CMD_CLEAR: r_adj_valid <= '0;
                            default: begin
                            end
                        endcase
                    end
                end
                S_ADD_WA: begin
                    r_adj_valid[r_a] <= 1'b1;
                    r_state          <= S_ADD_RB;
                end
                S_ADD_RB: r_state <= S_ADD_WB;
                S_ADD_WB: begin
                    r_adj_valid[r_b] <= 1'b1;
                    r_state          <= S_IDLE;
                end
                S_RD_OUT: begin
                    // labels hold own index until the first run
                    if (CW'(r_a) < n_eff) begin
                        r_res.vertex_community <= r_ran ? lab_q : r_a;
                    end else begin
                        r_res.vertex_community <= '0;
                    end
                    r_res.community_total <= r_last_total;
                    r_res.sweeps_done     <= r_last_sweeps;
                    r_res.is_run_report   <= 1'b0;
                    r_state               <= S_OUT;
                end
                S_OUT: begin
                    if (out_free) begin
                        r_out       <= r_res;
                        r_out_valid <= 1'b1;
                        r_state     <= S_IDLE;
                    end
                end
                S_INIT: begin
                    // every vertex starts in its own community
                    r_v <= r_v + CW'(1);
                    if (r_v == CW'(NV - 1)) begin
                        r_sweeps <= '0;
                        r_state  <= S_SW_START;
                    end
                end
                S_SW_START: begin
                    if (r_sweeps < r_max_iter) begin
                        r_sweeps  <= r_sweeps + 8'd1;
                        r_changed <= 1'b0;
                        r_v       <= '0;
                        r_state   <= S_V_START;
                    end else begin
                        r_state <= S_RN_INIT;
                    end
                end
                S_V_START: begin
                    if (r_v >= n_eff) begin
                        r_state <= r_changed ? S_SW_START : S_RN_INIT;
                    end else begin
                        r_state <= S_V_ROW;
                    end
                end
                S_V_ROW: begin
                    r_row <= r_adj_valid[r_v[VW-1:0]] ? (adj_q & cnt_mask) : '0;
                    r_own <= lab_q;
                    r_u   <= '0;
                    r_pass <= 2'd0;
                    if (!r_adj_valid[r_v[VW-1:0]] || ((adj_q & cnt_mask) == '0)) begin
                        r_v     <= r_v + CW'(1);
                        r_state <= S_V_START;
                    end else begin
                        r_state <= S_P_SCAN;
                    end
                end
                S_P_SCAN: begin
                    // pass 0 zeroes, pass 1 counts, pass 2 picks the best label
                    if (r_u >= n_eff) begin
                        r_u <= '0;
                        if (r_pass == 2'd2) begin
                            r_state <= S_V_UPD;
                        end else begin
                            r_pass <= r_pass + 2'd1;
                            if (r_pass == 2'd1) begin
                                r_best_cnt <= '0;
                                r_best     <= r_own;
                            end
                        end
                    end else if (!r_row[r_u[VW-1:0]]) begin
                        r_u <= r_u + CW'(1);
                    end else begin
                        r_state <= S_P_LAB;
                    end
                end
                S_P_LAB: begin
                    r_lab <= lab_q;
                    if (r_pass == 2'd0) begin
                        r_u     <= r_u + CW'(1);
                        r_state <= S_P_SCAN;
                    end else begin
                        r_state <= S_P_TAL;
                    end
                end
                S_P_TAL: begin
                    // higher count wins, a tie goes to the lower label
                    if (r_pass == 2'd2) begin
                        if ((tal_q > r_best_cnt) ||
                            ((tal_q == r_best_cnt) && (r_lab < r_best))) begin
                            r_best_cnt <= tal_q;
                            r_best     <= r_lab;
                        end
                    end
                    r_u     <= r_u + CW'(1);
                    r_state <= S_P_SCAN;
                end
                S_V_UPD: begin
                    if (r_best != r_own) begin
                        r_changed <= 1'b1;
                    end
                    r_v     <= r_v + CW'(1);
                    r_state <= S_V_START;
                end
                S_RN_INIT: begin
                    r_map_valid <= '0;
                    r_v         <= '0;
                    r_next      <= '0;
                    r_state     <= S_RN_ISSUE;
                end
                S_RN_ISSUE: begin
                    if (r_v >= n_eff) begin
                        r_last_total           <= r_next;
                        r_last_sweeps          <= r_sweeps;
                        r_ran                  <= 1'b1;
                        r_res.vertex_community <= '0;
                        r_res.community_total  <= r_next;
                        r_res.sweeps_done      <= r_sweeps;
                        r_res.is_run_report    <= 1'b1;
                        r_state                <= S_OUT;
                    end else begin
                        r_state <= S_RN_OLD;
                    end
                end
                S_RN_OLD: begin
                    // first appearance gets the next dense number
                    if (!r_map_valid[lab_q]) begin
                        r_map_valid[lab_q] <= 1'b1;
                        r_next             <= r_next + CW'(1);
                        r_v                <= r_v + CW'(1);
                        r_state            <= S_RN_ISSUE;
                    end else begin
                        r_state <= S_RN_MAP;
                    end
                end
                S_RN_MAP: begin
                    r_v     <= r_v + CW'(1);
                    r_state <= S_RN_ISSUE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end
endmodule
`default_nettype wire

// ----- hdl/lpc_checker.sv -----
`default_nettype none
`include "label_propagation_communities_unit_defines.svh"
module lpc_checker (
    input wire logic          i_clk,
    input wire logic          i_rst_n,
    input wire logic          o_out_valid,
    input wire logic          i_out_stall,
    input wire lpc_pkg::t_out o_out_data
);
    // a stalled result holds
    `LPC_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_out_valid && i_out_stall, o_out_valid && $stable(o_out_data))
    // run reports carry community number zero
    `LPC_ASSERT_NOW(a_run_id, i_clk, i_rst_n, o_out_valid && o_out_data.is_run_report, o_out_data.vertex_community == 6'd0)
    // never more communities than vertices
    `LPC_ASSERT_NOW(a_total, i_clk, i_rst_n, o_out_valid, o_out_data.community_total <= 7'd64)
endmodule

bind label_propagation_communities_unit lpc_checker u_lpc_checker (.*);
`default_nettype wire

// ----- tb/label_propagation_communities_unit_tb.sv -----
`default_nettype none
module label_propagation_communities_unit_tb;
    timeunit 1ns;
    timeprecision 1ps;

    // expected results waiting for the block, oldest first
    class community_scoreboard;
        lpc_pkg::t_out pending_results[$];
        int mismatch_count;
        int errors;

        // graph and label state of the modeled block
        bit [63:0] adj_rows [64];
        bit [5:0] labels [64];
        bit [6:0] community_total;
        bit [7:0] sweep_total;
        bit [6:0] vertex_count;
        bit [7:0] max_iter;

        function new();
            foreach (adj_rows[i]) begin
                adj_rows[i] = '0;
                labels[i] = 6'(i);
            end
            community_total = '0;
            sweep_total = '0;
            vertex_count = lpc_pkg::VCOUNT_RESET;
            max_iter = lpc_pkg::MAX_ITER_RESET;
        endfunction

        function void write_reg(logic idx, bit [7:0] value);
            if (idx == lpc_pkg::CFG_VERTEX_COUNT) vertex_count = value[6:0];
            else max_iter = value;
        endfunction

        function int active_vertices();
            return (vertex_count > lpc_pkg::VERTEX_SLOTS) ? lpc_pkg::VERTEX_SLOTS
                                                          : int'(vertex_count);
        endfunction

        function void queue_result(lpc_pkg::t_out res);
            pending_results = {pending_results, res};
        endfunction

        // label propagation, in place, then dense renumbering
        function void detect_communities();
            int n, sweeps, next_id;
            int tally [64];
            int remap [64];
            bit changed, any;
            int best, best_cnt;
            n = active_vertices();
            sweeps = 0;
            next_id = 0;
            foreach (labels[i]) labels[i] = 6'(i);
            for (int it = 0; it < max_iter; it++) begin
                changed = 0;
                sweeps++;
                for (int v = 0; v < n; v++) begin
                    any = 0;
                    foreach (tally[i]) tally[i] = 0;
                    for (int u = 0; u < n; u++) begin
                        if (adj_rows[v][u]) begin
                            any = 1;
                            tally[labels[u]]++;
                        end
                    end
                    if (!any) continue;
                    best = labels[v];
                    best_cnt = 0;
                    for (int c = 0; c < n; c++) begin
                        if (tally[c] > best_cnt) begin
                            best_cnt = tally[c];
                            best = c;
                        end
                    end
                    if (best != labels[v]) begin
                        labels[v] = 6'(best);
                        changed = 1;
                    end
                end
                if (!changed) break;
            end
            foreach (remap[i]) remap[i] = -1;
            for (int v = 0; v < n; v++) begin
                if (remap[labels[v]] < 0) remap[labels[v]] = next_id++;
                labels[v] = 6'(remap[labels[v]]);
            end
            community_total = 7'(next_id);
            sweep_total = 8'(sweeps);
        endfunction

        function void note_item(lpc_pkg::t_in item);
            lpc_pkg::t_out res;
            case (item.command)
                lpc_pkg::CMD_ADD: begin
                    adj_rows[item.src_vertex][item.dst_vertex] = 1'b1;
                    adj_rows[item.dst_vertex][item.src_vertex] = 1'b1;
                end
                lpc_pkg::CMD_CLEAR: foreach (adj_rows[i]) adj_rows[i] = '0;
                lpc_pkg::CMD_RUN: begin
                    detect_communities();
                    res.vertex_community = '0;
                    res.community_total = community_total;
                    res.sweeps_done = sweep_total;
                    res.is_run_report = 1'b1;
                    queue_result(res);
                end
                default: begin
                    res.vertex_community = (item.src_vertex < active_vertices())
                        ? labels[item.src_vertex] : 6'd0;
                    res.community_total = community_total;
                    res.sweeps_done = sweep_total;
                    res.is_run_report = 1'b0;
                    queue_result(res);
                end
            endcase
        endfunction

        function void check_result(lpc_pkg::t_out got);
            lpc_pkg::t_out want;
            if (pending_results.size() == 0) begin
                errors++;
                if (mismatch_count++ < 10) $display("unexpected result %p", got);
                return;
            end
            want = pending_results.pop_front();
            if (got !== want) begin
                errors++;
                if (mismatch_count++ < 10)
                    $display("mismatch: expected %p actual %p", want, got);
            end
        endfunction
    endclass

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_in_valid = 1'b0;
    logic o_in_stall;
    lpc_pkg::t_in i_in_data = '0;
    logic o_out_valid;
    logic i_out_stall = 1'b0;
    lpc_pkg::t_out o_out_data;
    logic i_cfg_we = 1'b0;
    logic i_cfg_index = 1'b0;
    logic [7:0] i_cfg_data = '0;

    community_scoreboard sb = new();
    int send_idle_pct = 0;
    int stall_pct = 0;
    int hold_off_cycles = 0;
    longint cycle_count = 0;

    always #10 i_clk = ~i_clk;

    label_propagation_communities_unit uut (
        .i_clk, .i_rst_n, .i_in_valid, .o_in_stall, .i_in_data,
        .o_out_valid, .i_out_stall, .o_out_data,
        .i_cfg_we, .i_cfg_index, .i_cfg_data
    );

    // generous limit for a dense 64-vertex run with a dozen sweeps
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > 60_000_000) begin
            $display("label_propagation_communities_unit_tb failed");
            $finish;
        end
    end

    // receiver: random stall, or a long hold-off when requested
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) sb.check_result(o_out_data);
        if (hold_off_cycles > 0) begin
            hold_off_cycles <= hold_off_cycles - 1;
            i_out_stall <= 1'b1;
        end else begin
            i_out_stall <= ($urandom_range(99) < stall_pct);
        end
    end

    // offer one item, holding it until accepted; valid drops only when idling
    task automatic send_item(lpc_pkg::t_in item);
        while ($urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data <= item;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        sb.note_item(item);
    endtask

    task automatic send_cmd(lpc_pkg::t_cmd c, int a, int b);
        lpc_pkg::t_in item;
        item.command = c;
        item.src_vertex = 6'(a);
        item.dst_vertex = 6'(b);
        send_item(item);
    endtask

    // wait for every result, then let the block settle before a register write
    task automatic drain();
        i_in_valid <= 1'b0;
        while (sb.pending_results.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
    endtask

    task automatic write_reg(logic idx, bit [7:0] value);
        i_cfg_we <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= value;
        @(posedge i_clk);
        sb.write_reg(idx, value);
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
    endtask

    // random item: mostly edges among a small community structure, some runs and reads
    task automatic random_item(int span);
        int r;
        r = $urandom_range(99);
        if (r < 60)
            send_cmd(lpc_pkg::CMD_ADD, $urandom_range(span - 1), $urandom_range(span - 1));
        else if (r < 68)
            send_cmd(lpc_pkg::CMD_ADD, $urandom_range(63), $urandom_range(63));
        else if (r < 76)
            send_cmd(lpc_pkg::CMD_RUN, 0, $urandom_range(63));
        else if (r < 97)
            send_cmd(lpc_pkg::CMD_READ, $urandom_range(63), $urandom_range(63));
        else
            send_cmd(lpc_pkg::CMD_CLEAR, $urandom_range(63), $urandom_range(63));
    endtask

    initial begin
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: reads before any run, extremes, self-loop, duplicates, ties
        send_cmd(lpc_pkg::CMD_READ, 0, 0);
        send_cmd(lpc_pkg::CMD_READ, 63, 63);
        send_cmd(lpc_pkg::CMD_ADD, 0, 1);
        send_cmd(lpc_pkg::CMD_ADD, 1, 0);
        send_cmd(lpc_pkg::CMD_ADD, 2, 2);
        send_cmd(lpc_pkg::CMD_ADD, 63, 62);
        send_cmd(lpc_pkg::CMD_ADD, 3, 4);
        send_cmd(lpc_pkg::CMD_ADD, 4, 5);
        send_cmd(lpc_pkg::CMD_RUN, 0, 0);
        send_cmd(lpc_pkg::CMD_READ, 1, 0);
        send_cmd(lpc_pkg::CMD_READ, 5, 0);
        send_cmd(lpc_pkg::CMD_READ, 62, 0);
        send_cmd(lpc_pkg::CMD_CLEAR, 0, 0);
        send_cmd(lpc_pkg::CMD_READ, 63, 0);
        drain();

        // zero iterations, then count zero, then count above the vertex range
        write_reg(lpc_pkg::CFG_MAX_ITER, 8'd0);
        send_cmd(lpc_pkg::CMD_ADD, 7, 8);
        send_cmd(lpc_pkg::CMD_RUN, 0, 0);
        send_cmd(lpc_pkg::CMD_READ, 8, 0);
        drain();
        write_reg(lpc_pkg::CFG_VERTEX_COUNT, 8'd0);
        write_reg(lpc_pkg::CFG_MAX_ITER, 8'd255);
        send_cmd(lpc_pkg::CMD_RUN, 0, 0);
        send_cmd(lpc_pkg::CMD_READ, 0, 0);
        drain();
        write_reg(lpc_pkg::CFG_VERTEX_COUNT, 8'd127);
        send_cmd(lpc_pkg::CMD_RUN, 0, 0);
        send_cmd(lpc_pkg::CMD_READ, 8, 0);
        drain();

        // random phases with varying idling and register settings
        for (int ph = 0; ph < 6; ph++) begin
            case (ph % 4)
                0: begin send_idle_pct = 0; stall_pct = 0; end
                1: begin send_idle_pct = 58; stall_pct = 0; end
                2: begin send_idle_pct = 0; stall_pct = 58; end
                default: begin send_idle_pct = 15; stall_pct = 15; end
            endcase
            write_reg(lpc_pkg::CFG_VERTEX_COUNT,
                      (ph == 5) ? 8'd64 : 8'($urandom_range(1, 20)));
            write_reg(lpc_pkg::CFG_MAX_ITER, (ph == 4) ? 8'd1 : 8'($urandom_range(1, 12)));
            if (ph == 2) hold_off_cycles = 3000;
            for (int k = 0; k < 19; k++) random_item(sb.active_vertices());
            send_cmd(lpc_pkg::CMD_RUN, 0, 0);
            drain();
        end

        while (sb.pending_results.size() != 0) @(posedge i_clk);
        repeat (50) @(posedge i_clk);
        if (sb.errors == 0 && sb.pending_results.size() == 0)
            $display("label_propagation_communities_unit_tb passed");
        else
            $display("label_propagation_communities_unit_tb failed");
        $finish;
    end
endmodule
`default_nettype wire
